/* rtl/dbpc_pkg.sv */
// Shared types and constants for the double-buffer playback cursor.
package dbpc_pkg;

  // Largest buffer the cursor walks; a larger size setting saturates here.
  localparam int unsigned MaxFrames = 65536;

  // Field and register widths.
  localparam int unsigned SizeW  = 17;
  localparam int unsigned CurW   = 16;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  // Request codes.
  typedef enum logic [ReqW-1:0] {
    REQ_FRAME  = 2'd0,
    REQ_REFILL = 2'd1,
    REQ_PLAY   = 2'd2,
    REQ_STOP   = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    ST_ADDR    = 2'd0,
    ST_SILENCE = 2'd1,
    ST_IDLE    = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSize   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStream = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLoop   = 2'd2;

  // One result beat.
  typedef struct packed {
    logic            stopped;
    logic            done_index;
    logic            half_done;
    logic [CurW-1:0] frame_address;
    status_e         status;
  } result_t;

endpackage

/* rtl/double_buffer_playback_cursor.sv */
// Playback cursor over a two-half audio buffer, one request beat in, one result beat out.
// An accepted request beat passes through the request register, then the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls; the cursor compare and
// increment sit between the two registers and update the state in the same cycle.
// Reset: not playing, cursor at zero, both halves marked consumed, size 1024,
// static mode, no looping.
module double_buffer_playback_cursor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [dbpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dbpc_pkg::SizeW-1:0]    cfg_data_i,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: req_type[1:0], half_index[2], zeros above.
  input  logic [dbpc_pkg::InDataW-1:0]  s_axis_tdata,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: status[1:0], frame_address[17:2], half_done[18], done_index[19],
  // stopped[20], zeros above.
  output logic [dbpc_pkg::OutDataW-1:0] m_axis_tdata
);
  import dbpc_pkg::*;

  // Configuration, held with the derived half sizes.
  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] half_q;
  logic [SizeW:0]   two_half_q;
  logic             stream_q;
  logic             loop_q;
  logic [SizeW-1:0] size_sat;
  logic [SizeW-1:0] half_new;

  // Playback state.
  logic             playing_q, playing_d;
  logic [CurW-1:0]  cursor_q, cursor_d;
  logic [1:0]       cons_q, cons_d;

  // Request register.
  logic             req_vld_q;
  req_e             req_q;
  logic             hidx_q;

  // Result register.
  logic             out_vld_q;
  result_t          out_q;
  result_t          res;

  logic             advance;
  logic             accept;

  // Working values for a frame request.
  logic [SizeW:0]   cur_x;
  logic             idx;
  logic             out_of_range;
  logic             last_frame;
  logic [SizeW-1:0] cur_inc;

  // Size saturation and half size for a new size setting.
  always_comb begin
    if (cfg_data_i > SizeW'(MaxFrames)) begin
      size_sat = SizeW'(MaxFrames);
    end else begin
      size_sat = cfg_data_i;
    end
    if (size_sat > SizeW'(1)) begin
      half_new = size_sat >> 1;
    end else begin
      half_new = size_sat;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= SizeW'(1024);
      half_q     <= SizeW'(512);
      two_half_q <= (SizeW+1)'(1024);
      stream_q   <= 1'b0;
      loop_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSize: begin
          size_q     <= size_sat;
          half_q     <= half_new;
          two_half_q <= {half_new, 1'b0};
        end
        CfgStream: stream_q <= cfg_data_i[0];
        CfgLoop:   loop_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the request stage moves on when the result register is free or drains.
  assign advance       = req_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !req_vld_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      req_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_e'(s_axis_tdata[ReqW-1:0]);
      hidx_q <= s_axis_tdata[ReqW];
    end
  end

  // Cursor position checks against the buffer and its halves.
  always_comb begin
    cur_x        = {2'b00, cursor_q};
    idx          = (cur_x >= {1'b0, half_q});
    out_of_range = (cur_x >= {1'b0, size_q}) || (cur_x >= two_half_q);
    if (stream_q) begin
      if (idx) begin
        last_frame = (cur_x == two_half_q - (SizeW+1)'(1));
      end else begin
        last_frame = (cur_x == {1'b0, half_q} - (SizeW+1)'(1));
      end
    end else begin
      last_frame = (cur_x == {1'b0, size_q} - (SizeW+1)'(1));
    end
    cur_inc = {1'b0, cursor_q} + SizeW'(1);
  end

  // Request decode and next state.
  always_comb begin
    playing_d         = playing_q;
    cursor_d          = cursor_q;
    cons_d            = cons_q;
    res.status        = ST_IDLE;
    res.frame_address = '0;
    res.half_done     = 1'b0;
    res.done_index    = 1'b0;
    res.stopped       = 1'b0;
    unique case (req_q)
      REQ_REFILL: begin
        cons_d[hidx_q] = 1'b0;
      end
      REQ_PLAY: begin
        playing_d = 1'b1;
      end
      REQ_STOP: begin
        if (playing_q) begin
          playing_d = 1'b0;
          cursor_d  = '0;
          cons_d    = 2'b11;
        end
      end
      REQ_FRAME: begin
        if (!playing_q) begin
          res.status = ST_IDLE;
        end else if (size_q == '0 || out_of_range) begin
          res.status = ST_RANGE;
        end else if (stream_q && cons_q[idx]) begin
          res.status = ST_SILENCE;
        end else begin
          res.status        = ST_ADDR;
          res.frame_address = cursor_q;
          // Wrap at the end of the buffer.
          if (cur_inc == size_q) begin
            cursor_d = '0;
          end else begin
            cursor_d = cur_inc[CurW-1:0];
          end
          // End of a half (or buffer, static): mark it consumed; stop unless looping.
          if (last_frame) begin
            cons_d[idx]    = 1'b1;
            res.half_done  = 1'b1;
            res.done_index = idx;
            if (!loop_q) begin
              playing_d   = 1'b0;
              cursor_d    = '0;
              cons_d      = 2'b11;
              res.stopped = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Playback state commits when a request moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      cursor_q  <= '0;
      cons_q    <= 2'b11;
    end else if (advance) begin
      playing_q <= playing_d;
      cursor_q  <= cursor_d;
      cons_q    <= cons_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_q};

endmodule
